[sv/pid_dm_pkg.sv]
`timescale 1ns / 1ps
// shared constants, types and saturation helpers of the dual mode pid controller
package pid_dm_pkg;

    localparam int DATA_W    = 32;
    localparam int FRAC_BITS = 16;
    localparam int DT_W      = 24;
    localparam int DT_FRAC   = 24;
    localparam int LIM_W     = DATA_W - 1;
    localparam int OP_W      = 2;
    localparam int CFG_IDX_W = 3;
    localparam int IN_DATA_W = ((DATA_W + DT_W + 7) / 8) * 8;
    localparam int WIDE_W    = DATA_W + 2;

    localparam logic [DATA_W-1:0] MAX_POS = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] MIN_NEG = {1'b1, {(DATA_W-1){1'b0}}};

    localparam logic [OP_W-1:0] OP_STEP  = 2'd0;
    localparam logic [OP_W-1:0] OP_RESET = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_MODE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SETPOINT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_INT_LIMIT = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_LIMIT = 3'd6;

    typedef struct packed {
        logic              flag;
        logic [DATA_W-1:0] value;
    } sat_word_t;

    typedef struct packed {
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
        logic              long_shift;
    } mul_req_t;

    typedef struct packed {
        logic done;
        logic sat;
    } div_stat_t;

    function automatic logic [WIDE_W-1:0] ext_wide(input logic [DATA_W-1:0] x);
        return {{(WIDE_W-DATA_W){x[DATA_W-1]}}, x};
    endfunction

    function automatic sat_word_t sat_wide(input logic [WIDE_W-1:0] v);
        sat_word_t r;
        if (v[WIDE_W-1:DATA_W-1] != {(WIDE_W-DATA_W+1){v[WIDE_W-1]}})
        begin
            r.flag  = 1'b1;
            r.value = v[WIDE_W-1] ? MIN_NEG : MAX_POS;
        end
        else
        begin
            r.flag  = 1'b0;
            r.value = v[DATA_W-1:0];
        end
        return r;
    endfunction

    function automatic sat_word_t add_sat(input logic [DATA_W-1:0] a,
                                          input logic [DATA_W-1:0] b);
        return sat_wide(ext_wide(a) + ext_wide(b));
    endfunction

    function automatic sat_word_t sub_sat(input logic [DATA_W-1:0] a,
                                          input logic [DATA_W-1:0] b);
        return sat_wide(ext_wide(a) - ext_wide(b));
    endfunction

    function automatic sat_word_t clamp_lim(input logic [DATA_W-1:0] v,
                                            input logic [LIM_W-1:0]  lim);
        sat_word_t         r;
        logic [DATA_W-1:0] pos;
        logic [DATA_W-1:0] neg;
        pos = {1'b0, lim};
        neg = -pos;
        if ($signed(v) > $signed(pos))
        begin
            r.flag  = 1'b1;
            r.value = pos;
        end
        else if ($signed(v) < $signed(neg))
        begin
            r.flag  = 1'b1;
            r.value = neg;
        end
        else
        begin
            r.flag  = 1'b0;
            r.value = v;
        end
        return r;
    endfunction

endpackage

[sv/pid_dm_mul.sv]
`timescale 1ns / 1ps
// shared two stage multiply, truncating shift and saturation unit
module pid_dm_mul (
    input  logic                  clk,
    input  pid_dm_pkg::mul_req_t  req,
    output pid_dm_pkg::sat_word_t res
);
    import pid_dm_pkg::*;

    localparam int PROD_W = 2 * DATA_W;

    logic [DATA_W-1:0] ua;
    logic [DATA_W-1:0] ub;
    logic [PROD_W-1:0] prod_reg;
    logic [PROD_W-1:0] prod_next;
    logic              neg_reg;
    logic              long_reg;
    logic [PROD_W-1:0] shifted;
    logic [PROD_W-1:0] lim;
    sat_word_t         res_reg;
    sat_word_t         res_next;

    // magnitudes, sign handled apart so the shift truncates toward zero
    assign ua        = req.a[DATA_W-1] ? (~req.a + 1'b1) : req.a;
    assign ub        = req.b[DATA_W-1] ? (~req.b + 1'b1) : req.b;
    assign prod_next = PROD_W'(ua) * PROD_W'(ub);

    always_comb
    begin
        shifted = long_reg ? (prod_reg >> DT_FRAC) : (prod_reg >> FRAC_BITS);
        lim     = neg_reg ? PROD_W'(MIN_NEG) : PROD_W'(MAX_POS);
        if (shifted > lim)
        begin
            res_next.flag  = 1'b1;
            res_next.value = neg_reg ? MIN_NEG : MAX_POS;
        end
        else
        begin
            res_next.flag  = 1'b0;
            res_next.value = neg_reg ? -shifted[DATA_W-1:0] : shifted[DATA_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        neg_reg  <= req.a[DATA_W-1] ^ req.b[DATA_W-1];
        long_reg <= req.long_shift;
        res_reg  <= res_next;
    end

    assign res = res_reg;

endmodule

[sv/pid_dm_div.sv]
`timescale 1ns / 1ps
// bit serial restoring divider for the derivative quotient (x * 2^24) / dt
module pid_dm_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [pid_dm_pkg::DATA_W-1:0] x,
    input  logic [pid_dm_pkg::DT_W-1:0]   dt,
    output pid_dm_pkg::div_stat_t         stat,
    output logic [pid_dm_pkg::DATA_W-1:0] q
);
    import pid_dm_pkg::*;

    localparam int HI_SH = DATA_W - DT_FRAC;
    localparam int CNT_W = $clog2(DATA_W);

    localparam logic [1:0] DV_IDLE = 2'd0;
    localparam logic [1:0] DV_RUN  = 2'd1;
    localparam logic [1:0] DV_FIX  = 2'd2;
    localparam logic [1:0] DV_DONE = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [DT_W-1:0]   rem_reg, rem_next;
    logic [DATA_W-1:0] quo_reg, quo_next;
    logic              neg_reg, neg_next;
    logic [DATA_W-1:0] res_reg, res_next;
    logic              sat_reg, sat_next;

    logic [DATA_W-1:0] ux;
    logic [DT_W:0]     trial;
    logic [DT_W:0]     diff;
    logic              ge;
    logic [DATA_W:0]   lim;

    assign ux    = x[DATA_W-1] ? (~x + 1'b1) : x;
    assign trial = {rem_reg, quo_reg[DATA_W-1]};
    assign diff  = trial - {1'b0, dt};
    assign ge    = trial >= {1'b0, dt};
    assign lim   = neg_reg ? {1'b0, MIN_NEG} : {1'b0, MAX_POS};

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        neg_next   = neg_reg;
        res_next   = res_reg;
        sat_next   = sat_reg;
        unique case (state_reg)
            DV_IDLE:
            begin
                if (start)
                begin
                    neg_next = x[DATA_W-1];
                    // zero dividend, or quotient too wide for the result
                    if (ux == '0)
                    begin
                        res_next   = '0;
                        sat_next   = 1'b0;
                        state_next = DV_DONE;
                    end
                    else if (ux[DATA_W-1:HI_SH] >= dt)
                    begin
                        res_next   = x[DATA_W-1] ? MIN_NEG : MAX_POS;
                        sat_next   = 1'b1;
                        state_next = DV_DONE;
                    end
                    else
                    begin
                        rem_next   = ux[DATA_W-1:HI_SH];
                        quo_next   = {ux[HI_SH-1:0], {DT_FRAC{1'b0}}};
                        cnt_next   = '0;
                        state_next = DV_RUN;
                    end
                end
            end
            DV_RUN:
            begin
                rem_next = ge ? diff[DT_W-1:0] : trial[DT_W-1:0];
                quo_next = {quo_reg[DATA_W-2:0], ge};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DATA_W - 1))
                begin
                    state_next = DV_FIX;
                end
            end
            DV_FIX:
            begin
                if ({1'b0, quo_reg} > lim)
                begin
                    res_next = neg_reg ? MIN_NEG : MAX_POS;
                    sat_next = 1'b1;
                end
                else
                begin
                    res_next = neg_reg ? -quo_reg : quo_reg;
                    sat_next = 1'b0;
                end
                state_next = DV_DONE;
            end
            DV_DONE:
            begin
                state_next = DV_IDLE;
            end
            default:
            begin
                state_next = DV_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DV_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        neg_reg <= neg_next;
        res_reg <= res_next;
        sat_reg <= sat_next;
    end

    assign stat.done = (state_reg == DV_DONE);
    assign stat.sat  = sat_reg;
    assign q         = res_reg;

endmodule

[sv/pid_controller_dual_mode.sv]
`timescale 1ns / 1ps
// top level: configuration registers, controller state and step sequencer
//
// Fixed point PID regulator (signed Q16.16, dt in unsigned Q0.24) with a
// positional and an incremental mode. Each request gives exactly one result.
// A control step is run by a small sequencer over one shared multiplier
// and saturating adders; the positional mode also uses a bit serial divider
// for the derivative quotient, one quotient bit per cycle. A positional step
// computes four products and then runs the divider, which skips its bit
// serial loop when the derivative term is zero or its quotient overflows; an
// incremental step computes three products and no quotient. A state reset,
// integral clear or unused operation code goes straight to the result. One
// request is in work at a time; the input side is ready again as soon as the
// result sits in the output register, even if it has not yet been taken, and a
// finished step waits while an earlier result is still held there.
// The user must see that configuration is written only while idle; the block
// itself does not enforce this.
module pid_controller_dual_mode (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // measured [31:0], step_time [55:32]
    input  logic [pid_dm_pkg::IN_DATA_W-1:0] s_axis_tdata,
    // operation [1:0]
    input  logic [pid_dm_pkg::OP_W-1:0]      s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // drive [31:0]
    output logic [pid_dm_pkg::DATA_W-1:0]    m_axis_tdata,
    // clamped [0]
    output logic                             m_axis_tuser,
    input  logic                             cfg_wen,
    input  logic [pid_dm_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  logic [pid_dm_pkg::DATA_W-1:0]    cfg_wdata
);
    import pid_dm_pkg::*;

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_ERR     = 4'd1;
    localparam logic [3:0] ST_DERR    = 4'd2;
    localparam logic [3:0] ST_MUL     = 4'd3;
    localparam logic [3:0] ST_MWAIT   = 4'd4;
    localparam logic [3:0] ST_MCAP    = 4'd5;
    localparam logic [3:0] ST_DIVGO   = 4'd6;
    localparam logic [3:0] ST_DIVWAIT = 4'd7;
    localparam logic [3:0] ST_ISUM    = 4'd8;
    localparam logic [3:0] ST_PSUM    = 4'd9;
    localparam logic [3:0] ST_POUT    = 4'd10;
    localparam logic [3:0] ST_IDELTA  = 4'd11;
    localparam logic [3:0] ST_IOUT    = 4'd12;
    localparam logic [3:0] ST_DONE    = 4'd13;

    localparam logic [1:0] MUL_IE  = 2'd0;
    localparam logic [1:0] MUL_IDT = 2'd1;
    localparam logic [1:0] MUL_P   = 2'd2;
    localparam logic [1:0] MUL_D   = 2'd3;

    logic [3:0]        state_reg, state_next;
    logic [1:0]        idx_reg, idx_next;

    logic              mode_reg;
    logic [DATA_W-1:0] setpoint_reg;
    logic [DATA_W-1:0] gain_p_reg;
    logic [DATA_W-1:0] gain_i_reg;
    logic [DATA_W-1:0] gain_d_reg;
    logic [LIM_W-1:0]  ilim_reg;
    logic [LIM_W-1:0]  olim_reg;

    logic [DATA_W-1:0] integ_reg, integ_next;
    logic [DATA_W-1:0] prev_err_reg, prev_err_next;
    logic [DATA_W-1:0] last_out_reg, last_out_next;
    logic              flag_reg, flag_next;
    logic              out_valid_reg, out_valid_next;

    logic [DATA_W-1:0] meas_reg, meas_next;
    logic [DT_W-1:0]   dt_reg, dt_next;
    logic [DATA_W-1:0] err_reg, err_next;
    logic [DATA_W-1:0] derr_reg, derr_next;
    logic [DATA_W-1:0] d_reg, d_next;
    logic [WIDE_W-1:0] sum_reg, sum_next;
    logic [DATA_W-1:0] out_drive_reg, out_drive_next;
    logic              out_clamped_reg, out_clamped_next;
    logic [DATA_W-1:0] term_reg [4];

    logic              in_fire;
    logic [1:0]        last_idx;
    mul_req_t          mul_req;
    sat_word_t         mul_res;
    logic              div_start;
    div_stat_t         div_stat;
    logic [DATA_W-1:0] div_q;
    sat_word_t         sw_a;
    sat_word_t         sw_b;

    pid_dm_mul u_mul (
        .clk (clk),
        .req (mul_req),
        .res (mul_res)
    );

    pid_dm_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .x     (term_reg[MUL_D]),
        .dt    (dt_reg),
        .stat  (div_stat),
        .q     (div_q)
    );

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign last_idx      = mode_reg ? MUL_P : MUL_D;
    assign div_start     = (state_reg == ST_DIVGO);

    // operand select of the shared multiplier
    always_comb
    begin
        unique case (idx_reg)
            MUL_IE:
            begin
                mul_req.a          = gain_i_reg;
                mul_req.b          = err_reg;
                mul_req.long_shift = 1'b0;
            end
            MUL_IDT:
            begin
                mul_req.a          = term_reg[MUL_IE];
                mul_req.b          = {{(DATA_W-DT_W){1'b0}}, dt_reg};
                mul_req.long_shift = 1'b1;
            end
            MUL_P:
            begin
                mul_req.a          = gain_p_reg;
                mul_req.b          = mode_reg ? derr_reg : err_reg;
                mul_req.long_shift = 1'b0;
            end
            default:
            begin
                mul_req.a          = gain_d_reg;
                mul_req.b          = derr_reg;
                mul_req.long_shift = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next       = state_reg;
        idx_next         = idx_reg;
        integ_next       = integ_reg;
        prev_err_next    = prev_err_reg;
        last_out_next    = last_out_reg;
        flag_next        = flag_reg;
        out_valid_next   = out_valid_reg;
        meas_next        = meas_reg;
        dt_next          = dt_reg;
        err_next         = err_reg;
        derr_next        = derr_reg;
        d_next           = d_reg;
        sum_next         = sum_reg;
        out_drive_next   = out_drive_reg;
        out_clamped_next = out_clamped_reg;
        sw_a             = '0;
        sw_b             = '0;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    meas_next = s_axis_tdata[DATA_W-1:0];
                    dt_next   = s_axis_tdata[DATA_W+DT_W-1:DATA_W];
                    flag_next = 1'b0;
                    unique case (s_axis_tuser)
                        OP_STEP:
                        begin
                            state_next = ST_ERR;
                        end
                        OP_RESET:
                        begin
                            integ_next    = '0;
                            prev_err_next = '0;
                            last_out_next = '0;
                            state_next    = ST_DONE;
                        end
                        OP_CLEAR:
                        begin
                            integ_next = '0;
                            state_next = ST_DONE;
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_ERR:
            begin
                sw_a       = sub_sat(setpoint_reg, meas_reg);
                err_next   = sw_a.value;
                flag_next  = flag_reg | sw_a.flag;
                state_next = ST_DERR;
            end
            ST_DERR:
            begin
                sw_a       = sub_sat(err_reg, prev_err_reg);
                derr_next  = sw_a.value;
                flag_next  = flag_reg | sw_a.flag;
                idx_next   = MUL_IE;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                state_next = ST_MWAIT;
            end
            ST_MWAIT:
            begin
                state_next = ST_MCAP;
            end
            ST_MCAP:
            begin
                flag_next = flag_reg | mul_res.flag;
                if (idx_reg == last_idx)
                begin
                    state_next = mode_reg ? ST_IDELTA : ST_DIVGO;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_DIVGO:
            begin
                state_next = ST_DIVWAIT;
            end
            ST_DIVWAIT:
            begin
                if (div_stat.done)
                begin
                    d_next     = div_q;
                    flag_next  = flag_reg | div_stat.sat;
                    state_next = ST_ISUM;
                end
            end
            ST_ISUM:
            begin
                // the integral clamp is not reported in the flag
                sw_a       = add_sat(integ_reg, term_reg[MUL_IDT]);
                sw_b       = clamp_lim(sw_a.value, ilim_reg);
                integ_next = sw_b.value;
                flag_next  = flag_reg | sw_a.flag;
                state_next = ST_PSUM;
            end
            ST_PSUM:
            begin
                sum_next   = ext_wide(term_reg[MUL_P]) + ext_wide(integ_reg) + ext_wide(d_reg);
                state_next = ST_POUT;
            end
            ST_POUT:
            begin
                sw_a          = sat_wide(sum_reg);
                sw_b          = clamp_lim(sw_a.value, olim_reg);
                last_out_next = sw_b.value;
                prev_err_next = err_reg;
                flag_next     = flag_reg | sw_a.flag | sw_b.flag;
                state_next    = ST_DONE;
            end
            ST_IDELTA:
            begin
                sw_a       = add_sat(term_reg[MUL_P], term_reg[MUL_IDT]);
                sw_b       = clamp_lim(sw_a.value, olim_reg);
                d_next     = sw_b.value;
                flag_next  = flag_reg | sw_a.flag | sw_b.flag;
                state_next = ST_IOUT;
            end
            ST_IOUT:
            begin
                sw_a          = add_sat(last_out_reg, d_reg);
                last_out_next = sw_a.value;
                prev_err_next = err_reg;
                flag_next     = flag_reg | sw_a.flag;
                state_next    = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next   = 1'b1;
                    out_drive_next   = last_out_reg;
                    out_clamped_next = flag_reg;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= MUL_IE;
            integ_reg     <= '0;
            prev_err_reg  <= '0;
            last_out_reg  <= '0;
            flag_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            integ_reg     <= integ_next;
            prev_err_reg  <= prev_err_next;
            last_out_reg  <= last_out_next;
            flag_reg      <= flag_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= 1'b0;
            setpoint_reg <= '0;
            gain_p_reg   <= '0;
            gain_i_reg   <= '0;
            gain_d_reg   <= '0;
            ilim_reg     <= '0;
            olim_reg     <= '0;
        end
        else if (cfg_wen)
        begin
            unique case (cfg_addr)
                REG_MODE:      mode_reg     <= cfg_wdata[0];
                REG_SETPOINT:  setpoint_reg <= cfg_wdata;
                REG_GAIN_P:    gain_p_reg   <= cfg_wdata;
                REG_GAIN_I:    gain_i_reg   <= cfg_wdata;
                REG_GAIN_D:    gain_d_reg   <= cfg_wdata;
                REG_INT_LIMIT: ilim_reg     <= cfg_wdata[LIM_W-1:0];
                REG_OUT_LIMIT: olim_reg     <= cfg_wdata[LIM_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        meas_reg        <= meas_next;
        dt_reg          <= dt_next;
        err_reg         <= err_next;
        derr_reg        <= derr_next;
        d_reg           <= d_next;
        sum_reg         <= sum_next;
        out_drive_reg   <= out_drive_next;
        out_clamped_reg <= out_clamped_next;
        if (state_reg == ST_MCAP)
        begin
            term_reg[idx_reg] <= mul_res.value;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_drive_reg;
    assign m_axis_tuser  = out_clamped_reg;

`ifndef SYNTHESIS
    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (state_reg != ST_IDLE))
        else $error("sequencer stayed idle after a request");

    a_deriv_only_positional: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL && idx_reg == MUL_D) |-> !mode_reg)
        else $error("derivative product issued in incremental mode");

    a_isum_after_div: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ISUM) |-> ($past(state_reg) == ST_DIVWAIT && !mode_reg))
        else $error("integral update out of sequence");

    a_div_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (state_reg == ST_DIVWAIT))
        else $error("divider finished while not awaited");
`endif

endmodule
